// File: hdl/aes_pkg.sv
// Package for the AES block cipher: types, S-box functions and round helpers.
// Used by the key expander, the round engine and the top level.
package aes_pkg;

    typedef logic [127:0] block_t;

    localparam int unsigned REG_KEY0 = 0;
    localparam int unsigned REG_KEY1 = 1;
    localparam int unsigned REG_KEY2 = 2;
    localparam int unsigned REG_KEY3 = 3;
    localparam int unsigned REG_IVH  = 4;
    localparam int unsigned REG_IVL  = 5;
    localparam int unsigned REG_KSZ  = 6;
    localparam int unsigned REG_MODE = 7;

    localparam logic [1:0] KSZ_192 = 2'd1;
    localparam logic [1:0] KSZ_256 = 2'd2;
    localparam logic KIND_DEC = 1'b1;

    typedef struct packed {
        logic       start;
        logic       decrypt;
        logic [3:0] nr;
    } eng_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic block_t enc_round(input block_t s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        block_t o;
        for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) t[r+4*c] = b[r+4*((c+r)%4)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!last)
            begin
                t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        enc_round = o;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
        gm = (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00)
           ^ (m[3] ? x8 : 8'h00);
    endfunction

    function automatic block_t inv_mix(input block_t s);
        logic [7:0] a0, a1, a2, a3;
        block_t o;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
            o[127-32*c -: 8] = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
            o[119-32*c -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
            o[111-32*c -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
            o[103-32*c -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
        end
        inv_mix = o;
    endfunction

    function automatic block_t inv_shift_sub(input block_t s);
        logic [7:0] b [16];
        block_t o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127-8*(r+4*c) -: 8] = inv_sbox(b[r+4*((c+4-r)%4)]);
        inv_shift_sub = o;
    endfunction

endpackage

// File: hdl/aes_key_expand.sv
// Key expander: produces one 32-bit key word per cycle and writes round keys.
// Depends on aes_pkg; writes into the round-key memory of the top level.
module aes_key_expand
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [255:0]        key,
    input  logic [3:0]          nk,
    input  logic [3:0]          nr,
    output logic                busy,
    output logic                wr_en,
    output logic [3:0]          wr_addr,
    output aes_pkg::block_t     wr_data
);
    import aes_pkg::*;

    typedef enum logic { S_IDLE, S_RUN } state_t;

    state_t       state_reg;
    logic [31:0]  win_reg [8];
    logic [5:0]   idx_reg;
    logic [2:0]   phase_reg;
    logic [7:0]   rcon_reg;
    logic [95:0]  part_reg;
    logic [5:0]   total;
    logic [31:0]  t_word;
    logic [31:0]  new_word;
    logic [31:0]  cur_word;
    logic         in_key;

    assign total  = {nr + 4'd1, 2'b00};
    assign in_key = idx_reg < {2'b00, nk};
    assign busy   = state_reg == S_RUN;

    always_comb
    begin
        t_word = win_reg[nk[2:0] - 3'd1];
        if (phase_reg == 3'd0)
            t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && phase_reg == 3'd4)
            t_word = sub_word(t_word);
        new_word = win_reg[0] ^ t_word;
        cur_word = in_key ? key[255 - 32*idx_reg[2:0] -: 32] : new_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
            wr_en     <= 1'b0;
        end
        else
        begin
            wr_en <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_RUN;
                        idx_reg   <= '0;
                        phase_reg <= '0;
                        rcon_reg  <= 8'h01;
                    end
                end
                S_RUN:
                begin
                    if (!in_key)
                    begin
                        if (phase_reg == 3'd0)
                            rcon_reg <= xtime(rcon_reg);
                        phase_reg <= (phase_reg == nk[2:0] - 3'd1) ? 3'd0 : phase_reg + 3'd1;
                    end
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        wr_en   <= 1'b1;
                        wr_addr <= idx_reg[5:2];
                        wr_data <= {part_reg, cur_word};
                    end
                    if (idx_reg == total - 6'd1)
                        state_reg <= S_IDLE;
                    idx_reg <= idx_reg + 6'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Window of the last nk words: slot 0 holds w[i-nk], slot nk-1 holds w[i-1].
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RUN)
        begin
            part_reg <= {part_reg[63:0], cur_word};
            if (in_key)
                win_reg[idx_reg[2:0]] <= cur_word;
            else
            begin
                for (int i = 0; i < 7; i++)
                    if (i + 1 < nk) win_reg[i] <= win_reg[i+1];
                win_reg[nk[2:0] - 3'd1] <= new_word;
            end
        end
    end

endmodule

// File: hdl/aes_round_engine.sv
// Round engine: one AES round per cycle over a round key read from memory.
// Depends on aes_pkg; the top level supplies the registered key read data.
module aes_round_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  aes_pkg::eng_ctl_t   ctl,
    input  aes_pkg::block_t     din,
    input  aes_pkg::block_t     rk,
    output logic [3:0]          rk_addr,
    output logic                done,
    output aes_pkg::block_t     dout
);
    import aes_pkg::*;

    typedef enum logic [1:0] { S_IDLE, S_FIRST, S_ROUND } state_t;

    state_t     state_reg;
    logic [3:0] rnd_reg;
    logic       dec_reg;
    logic [3:0] nr_reg;
    block_t     st_reg;
    block_t     dec_t;

    always_comb
    begin
        dec_t = inv_shift_sub(st_reg) ^ rk;
        if (rnd_reg != 4'd1)
            dec_t = inv_mix(dec_t);
    end

    // Address of the key used in the next cycle.
    always_comb
    begin
        rk_addr = '0;
        if (state_reg == S_IDLE)
            rk_addr = ctl.decrypt ? ctl.nr : 4'd0;
        else if (state_reg == S_FIRST)
            rk_addr = dec_reg ? nr_reg - 4'd1 : 4'd1;
        else
            rk_addr = dec_reg ? rnd_reg - 4'd2 : rnd_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            rnd_reg   <= '0;
            dec_reg   <= 1'b0;
            nr_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        state_reg <= S_FIRST;
                        dec_reg   <= ctl.decrypt;
                        nr_reg    <= ctl.nr;
                        st_reg    <= din;
                    end
                end
                S_FIRST:
                begin
                    st_reg    <= st_reg ^ rk;
                    rnd_reg   <= dec_reg ? nr_reg : 4'd1;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (dec_reg)
                    begin
                        st_reg <= dec_t;
                        rnd_reg <= rnd_reg - 4'd1;
                        if (rnd_reg == 4'd1)
                        begin
                            state_reg <= S_IDLE;
                            done      <= 1'b1;
                        end
                    end
                    else
                    begin
                        st_reg <= enc_round(st_reg, rnd_reg == nr_reg) ^ rk;
                        rnd_reg <= rnd_reg + 4'd1;
                        if (rnd_reg == nr_reg)
                        begin
                            state_reg <= S_IDLE;
                            done      <= 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign dout = st_reg;

endmodule

// File: hdl/aes_block_cipher_ecb_cbc_top.sv
// Top level of the AES block cipher with ECB and CBC chaining.
// Depends on aes_pkg, aes_key_expand and aes_round_engine.
//
// Input beats arrive on s_axis (tdata = data_high, data_low from bit 0 up;
// tuser = kind, chain_start), results leave on m_axis (tdata = result_high,
// result_low). Registers are written through the APB port: four key words,
// IV high and low, key size and chaining mode at byte addresses 8*i.
// For each accepted beat the round keys are first expanded from the key
// registers into a 15-entry round-key memory, one 32-bit word at a time
// and four words per round key; the round engine is started once the
// last round key has been written. The engine then adds the first round
// key in a load step and runs the rounds, reading one round key per cycle.
// Blocks are handled one at a time since CBC chains each block on the
// previous one: a new beat is accepted only after the last has finished.
// The result sits in an output register; the next beat is accepted while it
// waits, and a finished block is held inside, with the input stalled, until
// the output register is free. Reset clears the registers, the chain block
// and all control state; the round-key memory needs no clearing since each
// block refills it first.
module aes_block_cipher_ecb_cbc_top #(
    parameter int MAX_ROUND_KEYS = 15
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // data_high, data_low
    input  logic [1:0]   s_axis_tuser,   // kind, chain_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_high, result_low
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import aes_pkg::*;

    localparam int RKA = $clog2(MAX_ROUND_KEYS);

    typedef enum logic [1:0] { S_IDLE, S_EXPAND, S_CIPHER, S_HOLD } state_t;

    logic [63:0] key_reg [4];
    logic [63:0] ivh_reg, ivl_reg;
    logic [1:0]  ksz_reg;
    logic        mode_reg;

    state_t      state_reg;
    logic        kind_reg;
    block_t      blk_reg;
    block_t      chain_reg;
    logic        ovalid_reg;
    block_t      odata_reg;
    logic        exp_started_reg;

    block_t      rk_mem [MAX_ROUND_KEYS];
    block_t      rk_q;

    logic [3:0]  nk, nr;
    logic        exp_start, exp_busy, exp_wr;
    logic [3:0]  exp_addr, eng_addr;
    block_t      exp_data, eng_out, eng_in, res;
    eng_ctl_t    ctl;
    logic        eng_done;
    logic [2:0]  ridx;
    block_t      chain_in;

    always_comb
    begin
        nk = 4'd4; nr = 4'd10;
        if (ksz_reg == KSZ_192) begin nk = 4'd6; nr = 4'd12; end
        else if (ksz_reg == KSZ_256) begin nk = 4'd8; nr = 4'd14; end
        if (32'(nr) + 1 > MAX_ROUND_KEYS) begin nk = 4'd4; nr = 4'd10; end
    end

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];

    always_comb
    begin
        case (ridx)
            3'(REG_KEY0): prdata = key_reg[0];
            3'(REG_KEY1): prdata = key_reg[1];
            3'(REG_KEY2): prdata = key_reg[2];
            3'(REG_KEY3): prdata = key_reg[3];
            3'(REG_IVH):  prdata = ivh_reg;
            3'(REG_IVL):  prdata = ivl_reg;
            3'(REG_KSZ):  prdata = {62'h0, ksz_reg};
            3'(REG_MODE): prdata = {63'h0, mode_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            ivh_reg  <= '0;
            ivl_reg  <= '0;
            ksz_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (ridx)
                3'(REG_KEY0): key_reg[0] <= pwdata;
                3'(REG_KEY1): key_reg[1] <= pwdata;
                3'(REG_KEY2): key_reg[2] <= pwdata;
                3'(REG_KEY3): key_reg[3] <= pwdata;
                3'(REG_IVH):  ivh_reg <= pwdata;
                3'(REG_IVL):  ivl_reg <= pwdata;
                3'(REG_KSZ):  ksz_reg <= pwdata[1:0];
                3'(REG_MODE): mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr)
            rk_mem[exp_addr[RKA-1:0]] <= exp_data;
        rk_q <= rk_mem[eng_addr[RKA-1:0]];
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign exp_start     = state_reg == S_EXPAND && !exp_started_reg;

    aes_key_expand u_kexp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (exp_start),
        .key     ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .nk      (nk),
        .nr      (nr),
        .busy    (exp_busy),
        .wr_en   (exp_wr),
        .wr_addr (exp_addr),
        .wr_data (exp_data)
    );

    assign eng_in = (!kind_reg && mode_reg) ? blk_reg ^ chain_reg : blk_reg;
    assign ctl.start   = state_reg == S_EXPAND && exp_started_reg && !exp_busy && !exp_wr;
    assign ctl.decrypt = kind_reg == KIND_DEC;
    assign ctl.nr      = nr;

    aes_round_engine u_eng (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .din     (eng_in),
        .rk      (rk_q),
        .rk_addr (eng_addr),
        .done    (eng_done),
        .dout    (eng_out)
    );

    assign res = (kind_reg == KIND_DEC && mode_reg) ? eng_out ^ chain_reg : eng_out;
    assign chain_in = s_axis_tuser[1] ? {ivh_reg, ivl_reg} : chain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ovalid_reg      <= 1'b0;
            exp_started_reg <= 1'b0;
            chain_reg       <= '0;
            kind_reg        <= 1'b0;
            blk_reg         <= '0;
            odata_reg       <= '0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        kind_reg        <= s_axis_tuser[0];
                        chain_reg       <= chain_in;
                        blk_reg         <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        exp_started_reg <= 1'b0;
                        state_reg       <= S_EXPAND;
                    end
                end
                S_EXPAND:
                begin
                    exp_started_reg <= 1'b1;
                    if (ctl.start)
                        state_reg <= S_CIPHER;
                end
                S_CIPHER:
                begin
                    if (eng_done)
                    begin
                        if (!ovalid_reg || m_axis_tready)
                        begin
                            odata_reg  <= res;
                            ovalid_reg <= 1'b1;
                            if (mode_reg)
                                chain_reg <= (kind_reg == KIND_DEC) ? blk_reg : eng_out;
                            state_reg  <= S_IDLE;
                        end
                        else
                            state_reg  <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (!ovalid_reg || m_axis_tready)
                    begin
                        odata_reg  <= res;
                        ovalid_reg <= 1'b1;
                        if (mode_reg)
                            chain_reg <= (kind_reg == KIND_DEC) ? blk_reg : eng_out;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {odata_reg[63:0], odata_reg[127:64]};

endmodule
